### hw/rtl/qcr_pkg.sv
// Shared types, constants and helpers for the quadrature counter with speed readout.
package qcr_pkg;

  // Default configuration of the block
  localparam int CHANNELS_DEF   = 3;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed widths of the streaming words
  localparam int SPEED_FIELDS = 3;
  localparam int SPEED_W      = 32;
  localparam int DIV_W        = 16;
  localparam int CH_FIELD_W   = 2;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = SPEED_FIELDS * SPEED_W;

  // count * 60 is formed as (count << 6) - (count << 2); the product needs 6 more bits
  localparam int MUL_EXT = 6;
  localparam int SHL_HI  = 6;
  localparam int SHL_LO  = 2;

  // Channel match compare width (covers up to 32 channels)
  localparam int CH_CMP_W = 5;

  // Saturation limits of a speed field
  localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7fff_ffff;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

  // Input word kinds (carried on tuser)
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SIGN,
    S_DIV,
    S_DONE
  } state_t;

  // Per-cycle commands from the sequencer to every divider lane
  typedef struct packed {
    logic load;      // capture count snapshot
    logic mul;       // scale by sixty
    logic fix_sign;  // take magnitude, remember sign
    logic step;      // one restoring-division bit
  } lane_ctrl_t;

  // Phase code that follows prev in the forward direction
  function automatic logic [1:0] fwd_next(input logic [1:0] prev);
    logic [1:0] nxt;
    unique case (prev)
      2'b00: nxt = 2'b01;
      2'b01: nxt = 2'b11;
      2'b11: nxt = 2'b10;
      2'b10: nxt = 2'b00;
      default: nxt = 2'b01;
    endcase
    return nxt;
  endfunction

endpackage

### hw/rtl/qcr_counter.sv
// Per-channel position counters and stored phases; snapshot and clear on a tick.
module qcr_counter #(
  parameter int CHANNELS   = qcr_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = qcr_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   sample_en,
  input  logic                                   tick_en,
  input  logic [qcr_pkg::CH_FIELD_W-1:0]         channel,
  input  logic [1:0]                             phase,
  output logic [COUNT_BITS-1:0]                  snap [qcr_pkg::SPEED_FIELDS]
);

  logic [COUNT_BITS-1:0] count_r   [CHANNELS];
  logic [COUNT_BITS-1:0] count_nxt [CHANNELS];
  logic [1:0]            phase_r   [CHANNELS];
  logic [1:0]            phase_nxt [CHANNELS];
  logic [CHANNELS-1:0]   hit;
  logic [COUNT_BITS-1:0] sel_count;
  logic [1:0]            sel_phase;
  logic [COUNT_BITS-1:0] upd_count;

  // Channel decode and read of the addressed entry
  always_comb begin
    sel_count = '0;
    sel_phase = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      hit[i] = ({{(qcr_pkg::CH_CMP_W-qcr_pkg::CH_FIELD_W){1'b0}}, channel}
                == qcr_pkg::CH_CMP_W'(i));
      if (hit[i]) begin
        sel_count = count_r[i];
        sel_phase = phase_r[i];
      end
    end
  end

  // Forward step counts up, anything else counts down
  assign upd_count = (qcr_pkg::fwd_next(sel_phase) == phase) ? sel_count + 1'b1
                                                             : sel_count - 1'b1;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      count_nxt[i] = count_r[i];
      phase_nxt[i] = phase_r[i];
      if (tick_en) begin
        count_nxt[i] = '0;
      end else if (sample_en && hit[i]) begin
        count_nxt[i] = upd_count;
        phase_nxt[i] = phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= '0;
        phase_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= count_nxt[i];
        phase_r[i] <= phase_nxt[i];
      end
    end
  end

  // Reported channels; missing ones read as zero
  for (genvar j = 0; j < qcr_pkg::SPEED_FIELDS; j++) begin : g_snap
    if (j < CHANNELS) begin : g_have
      assign snap[j] = count_r[j];
    end else begin : g_none
      assign snap[j] = '0;
    end
  end

endmodule

### hw/rtl/qcr_lane.sv
// One speed lane: scale by sixty, then bit-serial restoring divide and saturate.
module qcr_lane #(
  parameter int COUNT_BITS = qcr_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  qcr_pkg::lane_ctrl_t          ctrl,
  input  logic [COUNT_BITS-1:0]        count_in,
  input  logic [qcr_pkg::DIV_W-1:0]    div_in,
  output logic [qcr_pkg::SPEED_W-1:0]  speed
);

  localparam int PROD_W = COUNT_BITS + qcr_pkg::MUL_EXT;
  localparam int QX_W   = (PROD_W > qcr_pkg::SPEED_W + 1) ? PROD_W : qcr_pkg::SPEED_W + 1;

  // acc_r holds the dividend and collects quotient bits from the bottom
  logic [PROD_W-1:0]          acc_r;
  logic [qcr_pkg::DIV_W-1:0]  rem_r;
  logic                       neg_r;
  logic [qcr_pkg::DIV_W+1:0]  diff;
  logic                       qbit;
  logic [QX_W-1:0]            qx;

  // Trial subtract of the divisor from the shifted remainder
  assign diff = {1'b0, rem_r, acc_r[PROD_W-1]} - {2'b00, div_in};
  assign qbit = ~diff[qcr_pkg::DIV_W+1];

  // payload only, the sequencer always loads before use
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc_r <= {{qcr_pkg::MUL_EXT{count_in[COUNT_BITS-1]}}, count_in};
    end else if (ctrl.mul) begin
      acc_r <= (acc_r << qcr_pkg::SHL_HI) - (acc_r << qcr_pkg::SHL_LO);
    end else if (ctrl.fix_sign) begin
      neg_r <= acc_r[PROD_W-1];
      acc_r <= acc_r[PROD_W-1] ? -acc_r : acc_r;
      rem_r <= '0;
    end else if (ctrl.step) begin
      acc_r <= {acc_r[PROD_W-2:0], qbit};
      if (qbit) begin
        rem_r <= diff[qcr_pkg::DIV_W-1:0];
      end else begin
        rem_r <= {rem_r[qcr_pkg::DIV_W-2:0], acc_r[PROD_W-1]};
      end
    end
  end

  // Apply sign and clamp to the 32-bit signed range
  assign qx = QX_W'(acc_r);

  always_comb begin
    if (!neg_r) begin
      speed = (|qx[QX_W-1:qcr_pkg::SPEED_W-1]) ? qcr_pkg::SPEED_MAX
                                                : qx[qcr_pkg::SPEED_W-1:0];
    end else begin
      speed = ((|qx[QX_W-1:qcr_pkg::SPEED_W]) ||
               (qx[qcr_pkg::SPEED_W-1] && (|qx[qcr_pkg::SPEED_W-2:0])))
              ? qcr_pkg::SPEED_MIN : -qx[qcr_pkg::SPEED_W-1:0];
    end
  end

endmodule

### hw/rtl/qcr_seq.sv
// Sequencer for the speed computation: scale, sign, division bits, hand-off.
module qcr_seq #(
  parameter int STEPS = qcr_pkg::COUNT_BITS_DEF + qcr_pkg::MUL_EXT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_free,
  output qcr_pkg::lane_ctrl_t  ctrl,
  output logic                 busy,
  output logic                 done
);

  localparam int STEP_W = $clog2(STEPS);

  qcr_pkg::state_t   state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qcr_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and lane commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    done      = 1'b0;
    busy      = 1'b1;
    unique case (state_r)
      qcr_pkg::S_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
        if (start) state_nxt = qcr_pkg::S_MUL;
      end
      qcr_pkg::S_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = qcr_pkg::S_SIGN;
      end
      qcr_pkg::S_SIGN: begin
        ctrl.fix_sign = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = qcr_pkg::S_DIV;
      end
      qcr_pkg::S_DIV: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(STEPS - 1)) state_nxt = qcr_pkg::S_DONE;
      end
      qcr_pkg::S_DONE: begin
        // wait for room in the output register
        if (out_free) begin
          done      = 1'b1;
          state_nxt = qcr_pkg::S_IDLE;
        end
      end
      default: state_nxt = qcr_pkg::S_IDLE;
    endcase
  end

endmodule

### hw/rtl/quadrature_counter_rpm.sv
// Three-channel quadrature counter with per-period speed readout (top level).
// Sample words: accepted one per cycle, also while a speed computation runs.
// Tick word: after acceptance the count snapshot is loaded, then the lanes scale it,
//   take the sign, produce one quotient bit per cycle in the serial divider lanes
//   and hand off to the output register, waiting while it is full. A next tick waits until the divider is free.
// Reset (rst_n low, synchronous) clears counts, phases, sequencer and output valid,
// and sets pulses_per_round to 1.
module quadrature_counter_rpm #(
  parameter int CHANNELS   = qcr_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = qcr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [qcr_pkg::IN_DATA_W-1:0]     in_tdata,   // channel[1:0], level_a, level_b, pad
  input  logic                              in_tuser,   // kind
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [qcr_pkg::OUT_DATA_W-1:0]    out_tdata,  // speed_ch0, speed_ch1, speed_ch2
  // configuration
  input  logic                              cfg_we,
  input  logic [qcr_pkg::DIV_W-1:0]         cfg_wdata   // pulses_per_round
);

  localparam int STEPS = COUNT_BITS + qcr_pkg::MUL_EXT;

  logic                           busy, done, out_free;
  logic                           in_fire, sample_en, tick_en;
  qcr_pkg::lane_ctrl_t            ctrl;
  logic [COUNT_BITS-1:0]          snap  [qcr_pkg::SPEED_FIELDS];
  logic [qcr_pkg::SPEED_W-1:0]    speed [qcr_pkg::SPEED_FIELDS];
  logic [qcr_pkg::DIV_W-1:0]      ppr_r;
  logic [qcr_pkg::DIV_W-1:0]      div_r;
  logic                           out_valid_r;
  logic [qcr_pkg::OUT_DATA_W-1:0] out_data_r;

  // Samples always pass; a tick needs an idle divider
  assign in_tready = !busy || (in_tuser == qcr_pkg::KIND_SAMPLE);
  assign in_fire   = in_tvalid && in_tready;
  assign sample_en = in_fire && (in_tuser == qcr_pkg::KIND_SAMPLE);
  assign tick_en   = in_fire && (in_tuser == qcr_pkg::KIND_TICK);
  assign out_free  = !out_valid_r || out_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= qcr_pkg::DIV_W'(1);
    end else if (cfg_we) begin
      ppr_r <= cfg_wdata;
    end
  end

  // Divisor captured at the tick; zero counts as one
  always_ff @(posedge clk) begin
    if (tick_en) begin
      div_r <= (ppr_r == '0) ? qcr_pkg::DIV_W'(1) : ppr_r;
    end
  end

  qcr_counter #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .tick_en   (tick_en),
    .channel   (in_tdata[qcr_pkg::CH_FIELD_W-1:0]),
    .phase     ({in_tdata[2], in_tdata[3]}),
    .snap      (snap)
  );

  qcr_seq #(
    .STEPS (STEPS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tick_en),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .done     (done)
  );

  for (genvar j = 0; j < qcr_pkg::SPEED_FIELDS; j++) begin : g_lane
    qcr_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .count_in (snap[j]),
      .div_in   (div_r),
      .speed    (speed[j])
    );
  end

  // Output register, holds the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= {speed[2], speed[1], speed[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### verif/tb_quadrature_counter_rpm.sv
// Self-checking testbench for the quadrature counter with speed readout.
`timescale 1ns / 1ps

module tb_quadrature_counter_rpm;

  localparam int NUM_CH     = qcr_pkg::CHANNELS_DEF;
  localparam int SETTLE_CYC = 50;     // settle time in drain, after the last speed word
  localparam int PHASES     = 4;

  // tracks encoder counts and phases, predicts the speed word of each tick
  class speed_tracker;
    logic [qcr_pkg::COUNT_BITS_DEF-1:0] counts [NUM_CH];
    logic [1:0]                         phases [NUM_CH];
    logic [qcr_pkg::DIV_W-1:0]          divisor;
    logic [qcr_pkg::OUT_DATA_W-1:0]     pending_speeds [$];
    int                                 mismatches;

    function new();
      for (int i = 0; i < NUM_CH; i++) begin
        counts[i] = '0;
        phases[i] = 2'b00;
      end
      divisor    = 16'd1;
      mismatches = 0;
    endfunction

    function void set_divisor(logic [qcr_pkg::DIV_W-1:0] v);
      divisor = v;
    endfunction

    function int pending();
      return pending_speeds.size();
    endfunction

    // forward order 00 -> 01 -> 11 -> 10 -> 00
    function logic [1:0] forward_of(logic [1:0] p);
      case (p)
        2'b00: return 2'b01;
        2'b01: return 2'b11;
        2'b11: return 2'b10;
        default: return 2'b00;
      endcase
    endfunction

    // count * 60 / divisor, truncated toward zero, saturated to 32 bits
    function logic [qcr_pkg::SPEED_W-1:0] rpm_of(logic [qcr_pkg::COUNT_BITS_DEF-1:0] cnt);
      int     cnt_s;
      longint div;
      longint quot;
      cnt_s = cnt;
      div   = divisor;
      if (div == 0) div = 1;
      quot = (longint'(cnt_s) * 60) / div;
      if (quot > longint'(qcr_pkg::SPEED_MAX)) return qcr_pkg::SPEED_MAX;
      if (quot < -longint'(qcr_pkg::SPEED_MAX) - 1) return qcr_pkg::SPEED_MIN;
      return quot[qcr_pkg::SPEED_W-1:0];
    endfunction

    function void note_word(logic kind, logic [qcr_pkg::IN_DATA_W-1:0] word);
      logic [1:0]                     ch;
      logic [1:0]                     ph;
      logic [qcr_pkg::OUT_DATA_W-1:0] speeds;
      if (kind == qcr_pkg::KIND_SAMPLE) begin
        ch = word[1:0];
        ph = {word[2], word[3]};
        // samples for a channel that does not exist are dropped
        if (ch < NUM_CH) begin
          if (forward_of(phases[ch]) == ph) counts[ch] = counts[ch] + 1'b1;
          else counts[ch] = counts[ch] - 1'b1;
          phases[ch] = ph;
        end
      end else begin
        for (int i = 0; i < qcr_pkg::SPEED_FIELDS; i++)
          speeds[i*qcr_pkg::SPEED_W +: qcr_pkg::SPEED_W] =
            (i < NUM_CH) ? rpm_of(counts[i]) : '0;
        pending_speeds.push_back(speeds);
        for (int i = 0; i < NUM_CH; i++) counts[i] = '0;
      end
    endfunction

    function void log_mismatch(string what, int ch, logic [qcr_pkg::SPEED_W-1:0] want,
                               logic [qcr_pkg::SPEED_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s) ch%0d: expected %0d, got %0d", what, ch,
                 $signed(want), $signed(got));
    endfunction

    function void check_speeds(logic [qcr_pkg::OUT_DATA_W-1:0] got);
      logic [qcr_pkg::OUT_DATA_W-1:0] want;
      if (pending_speeds.size() == 0) begin
        log_mismatch("unexpected word", 0, '0, got[qcr_pkg::SPEED_W-1:0]);
        return;
      end
      want = pending_speeds.pop_front();
      for (int i = 0; i < qcr_pkg::SPEED_FIELDS; i++)
        if (want[i*qcr_pkg::SPEED_W +: qcr_pkg::SPEED_W] !==
            got[i*qcr_pkg::SPEED_W +: qcr_pkg::SPEED_W])
          log_mismatch("speed", i, want[i*qcr_pkg::SPEED_W +: qcr_pkg::SPEED_W],
                       got[i*qcr_pkg::SPEED_W +: qcr_pkg::SPEED_W]);
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [qcr_pkg::IN_DATA_W-1:0]  in_tdata   = '0;   // channel[1:0], level_a, level_b, pad
  logic                           in_tuser   = 1'b0; // kind
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [qcr_pkg::OUT_DATA_W-1:0] out_tdata;         // speed_ch0, speed_ch1, speed_ch2
  logic                           cfg_we     = 1'b0;
  logic [qcr_pkg::DIV_W-1:0]      cfg_wdata  = '0;   // pulses_per_round

  int           send_idle  = 0;   // percent of cycles the sender holds off
  int           recv_stall = 0;   // percent of cycles the receiver stalls
  logic [1:0]   enc_level [NUM_CH];
  logic         enc_dir   [NUM_CH];
  speed_tracker tracker;

  quadrature_counter_rpm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_speeds(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // one input word, with a random hold-off in front
  task automatic send_word(input logic kind, input logic [qcr_pkg::IN_DATA_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    tracker.note_word(kind, word);
  endtask

  task automatic sample(input logic [1:0] ch, input logic [1:0] ph);
    send_word(qcr_pkg::KIND_SAMPLE, {4'b0000, ph[0], ph[1], ch});
  endtask

  task automatic tick(input logic [3:0] junk);
    send_word(qcr_pkg::KIND_TICK, {4'b0000, junk});
  endtask

  // stop sending, let every speed word arrive and the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [qcr_pkg::DIV_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_divisor(v);
  endtask

  // neighbor phase of the simulated encoder in the given direction
  function automatic logic [1:0] enc_step(input logic [1:0] p, input logic fwd);
    case (p)
      2'b00: return fwd ? 2'b01 : 2'b10;
      2'b01: return fwd ? 2'b11 : 2'b00;
      2'b11: return fwd ? 2'b10 : 2'b01;
      default: return fwd ? 2'b00 : 2'b11;
    endcase
  endfunction

  // mostly clean encoder motion, some noise, ignored channel and random ticks
  task automatic run_random(input int n_words, input int n_ticks);
    int         sent;
    int         ticks;
    int         r;
    logic [1:0] ch;
    logic [1:0] ph;
    logic [3:0] junk;
    sent  = 0;
    ticks = 0;
    while (sent < n_words || ticks < n_ticks) begin
      r    = $urandom_range(0, 99);
      ph   = $urandom_range(0, 3);
      junk = $urandom_range(0, 15);
      if (r < 5) begin
        tick(junk);
        ticks++;
        sent++;
      end else if (r < 9) begin
        sample(2'd3, ph);
      end else if (r < 17) begin
        ch = $urandom_range(0, NUM_CH - 1);
        enc_level[ch] = ph;
        sample(ch, ph);
        sent++;
      end else begin
        ch = $urandom_range(0, NUM_CH - 1);
        if ($urandom_range(0, 19) == 0) enc_dir[ch] = ~enc_dir[ch];
        enc_level[ch] = enc_step(enc_level[ch], enc_dir[ch]);
        sample(ch, enc_level[ch]);
        sent++;
      end
    end
  endtask

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                        stall_of [PHASES];
    int                        idle_of  [PHASES];
    logic [qcr_pkg::DIV_W-1:0] div_of   [PHASES];
    tracker = new();
    idle_of  = '{0, 60, 0, 31};
    stall_of = '{0, 0, 60, 31};
    div_of   = '{16'd1, 16'd3, 16'd0, 16'd7};
    div_of[2] = $urandom_range(4, 60);
    for (int i = 0; i < NUM_CH; i++) begin
      enc_level[i] = 2'b00;
      enc_dir[i]   = $urandom_range(0, 1);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full forward cycle on ch0 at the reset divisor
    sample(2'd0, 2'b01);
    sample(2'd0, 2'b11);
    sample(2'd0, 2'b10);
    sample(2'd0, 2'b00);
    // reverse steps, no change and a jump count down; ch2 ends with a forward step
    sample(2'd1, 2'b10);
    sample(2'd1, 2'b11);
    sample(2'd1, 2'b11);
    sample(2'd1, 2'b00);
    sample(2'd2, 2'b00);
    sample(2'd2, 2'b11);
    sample(2'd2, 2'b10);
    // channel out of range is ignored
    sample(2'd3, 2'b11);
    // tick with the four low don't-care bits set
    tick(4'hf);
    // zero divisor behaves as one
    write_divisor(16'd0);
    sample(2'd0, 2'b01);
    sample(2'd0, 2'b11);
    sample(2'd2, 2'b00);
    sample(2'd1, 2'b01);
    tick(4'h0);
    tick(4'h5);
    // largest divisor, negative count
    write_divisor(16'hffff);
    sample(2'd1, 2'b00);
    sample(2'd1, 2'b00);
    tick(4'ha);
    for (int i = 0; i < NUM_CH; i++) enc_level[i] = tracker.phases[i];

    // random phases with different divisors and flow control
    for (int p = 0; p < PHASES; p++) begin
      write_divisor(div_of[p]);
      send_idle  = idle_of[p];
      recv_stall = stall_of[p];
      run_random(200, 10);
    end

    drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
